/* design/rspd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rspd_pkg
// Shared constants, types and helpers for the debug-link packet deframer.
// ----------------------------------------------------------------------------
package rspd_pkg;

  // Longest payload accepted before a packet is cut off and rejected.
  localparam int MaxPayload = 1024;
  // The length counter must be able to hold MaxPayload itself.
  localparam int LenW = $clog2(MaxPayload + 1);

  // Framing characters of the link.
  localparam logic [7:0] ChStart = 8'h24;  // '$'
  localparam logic [7:0] ChEnd   = 8'h23;  // '#'
  localparam logic [7:0] ChBreak = 8'h03;
  localparam logic [7:0] ChAck   = 8'h2B;  // '+'
  localparam logic [7:0] ChNak   = 8'h2D;  // '-'

  // Deframer phases.
  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhBody = 2'd1;
  localparam logic [1:0] PhHex1 = 2'd2;
  localparam logic [1:0] PhHex2 = 2'd3;

  // Event codes reported with each beat.
  localparam logic [2:0] EvNone  = 3'd0;
  localparam logic [2:0] EvData  = 3'd1;
  localparam logic [2:0] EvGood  = 3'd2;
  localparam logic [2:0] EvBad   = 3'd3;
  localparam logic [2:0] EvAck   = 3'd4;
  localparam logic [2:0] EvNak   = 3'd5;
  localparam logic [2:0] EvBreak = 3'd6;
  localparam logic [2:0] EvStray = 3'd7;

  // Reply codes towards the partner.
  localparam logic [1:0] RpNone = 2'd0;
  localparam logic [1:0] RpAck  = 2'd1;
  localparam logic [1:0] RpNak  = 2'd2;

  // One result beat.
  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] data_byte;
    logic [1:0] reply;
  } res_t;

  // Lowercase hex digit decode: bit 4 is the valid flag, bits 3:0 the value.
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'b0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, b[3:0]};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

/* design/rspd_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rspd_core
// Deframer state and the per-byte update: classifies one byte and yields
// the result beat that it causes.
// ----------------------------------------------------------------------------
module rspd_core
  import rspd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] rx_byte,
  output res_t       res
);

  logic [1:0]      phase, phase_next;
  logic [7:0]      running_sum, running_sum_next;
  logic [3:0]      high_nibble, high_nibble_next;
  logic            high_nibble_valid, high_nibble_valid_next;
  logic [LenW-1:0] payload_length, payload_length_next;

  logic [4:0] digit;
  logic [7:0] cksum;

  // Checksum value received in the two hex digits, partial on a bad digit.
  always_comb begin
    digit = hex_digit(rx_byte);
    cksum = 8'h00;
    if (high_nibble_valid) begin
      cksum = digit[4] ? {high_nibble, digit[3:0]} : {4'h0, high_nibble};
    end
  end

  // Per-byte state update and result.
  always_comb begin
    phase_next             = phase;
    running_sum_next       = running_sum;
    high_nibble_next       = high_nibble;
    high_nibble_valid_next = high_nibble_valid;
    payload_length_next    = payload_length;
    res = '{event_res: EvNone, data_byte: 8'h00, reply: RpNone};
    unique case (phase)
      PhIdle: begin
        if (rx_byte == ChAck) begin
          res.event_res = EvAck;
        end else if (rx_byte == ChNak) begin
          res.event_res = EvNak;
        end else if (rx_byte == ChBreak) begin
          res.event_res = EvBreak;
        end else if (rx_byte == ChStart) begin
          phase_next             = PhBody;
          running_sum_next       = 8'h00;
          payload_length_next    = '0;
          high_nibble_next       = 4'h0;
          high_nibble_valid_next = 1'b0;
        end else begin
          res.event_res = EvStray;
          res.reply     = RpNak;
        end
      end
      PhBody: begin
        if (rx_byte == ChEnd) begin
          phase_next = PhHex1;
        end else if (payload_length >= LenW'(MaxPayload)) begin
          // Overlong payload: drop the packet.
          res.event_res = EvBad;
          res.data_byte = running_sum;
          res.reply     = RpNak;
          phase_next    = PhIdle;
        end else begin
          res.event_res       = EvData;
          res.data_byte       = rx_byte;
          running_sum_next    = running_sum + rx_byte;
          payload_length_next = payload_length + LenW'(1);
        end
      end
      PhHex1: begin
        high_nibble_valid_next = digit[4];
        high_nibble_next       = digit[3:0];
        phase_next             = PhHex2;
      end
      PhHex2: begin
        res.data_byte = running_sum;
        if (cksum == running_sum) begin
          res.event_res = EvGood;
          res.reply     = RpAck;
        end else begin
          res.event_res = EvBad;
          res.reply     = RpNak;
        end
        phase_next = PhIdle;
      end
      default: begin
        phase_next = PhIdle;
      end
    endcase
  end

  // State registers advance once per byte taken from the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PhIdle;
      running_sum       <= 8'h00;
      high_nibble       <= 4'h0;
      high_nibble_valid <= 1'b0;
      payload_length    <= '0;
    end else if (step) begin
      phase             <= phase_next;
      running_sum       <= running_sum_next;
      high_nibble       <= high_nibble_next;
      high_nibble_valid <= high_nibble_valid_next;
      payload_length    <= payload_length_next;
    end
  end

endmodule

/* design/rsp_packet_deframer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsp_packet_deframer
// Byte-serial deframer for the debug-link remote serial protocol.
// ----------------------------------------------------------------------------
// Usage:
//   Received link bytes enter on rx_byte with in_valid/in_ready; every
//   accepted beat yields exactly one result beat on event_res, data_byte and
//   reply with out_valid/out_ready, in the same order.
//   An accepted byte is held in an input register; the deframer then
//   classifies it and loads the result register once that register is
//   free to take a new beat.
//   Throughput is one byte per cycle while the receiver takes every result,
//   as the state updates for one byte on each step between the two registers.
//   When the receiver stalls, the result register holds its beat and the
//   input register takes one more byte; in_ready then falls until the
//   result is taken.
//   Reset clears both registers' valid flags and returns the deframer to
//   idle with a zero sum, length and checksum digit.
// ----------------------------------------------------------------------------
module rsp_packet_deframer
  import rspd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] event_res,
  output logic [7:0] data_byte,
  output logic [1:0] reply
);

  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       out_free;
  logic       step;
  res_t       res;
  res_t       out_res;

  // The result register can load when empty or when its beat leaves now.
  assign out_free = !out_valid || out_ready;
  assign step     = hold_valid && out_free;
  assign in_ready = !hold_valid || out_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold_byte <= rx_byte;
    end
  end

  rspd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rx_byte (hold_byte),
    .res     (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= res;
    end
  end

  assign event_res = out_res.event_res;
  assign data_byte = out_res.data_byte;
  assign reply     = out_res.reply;

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the debug-link packet deframer. A queue of link
// bytes feeds a valid/ready driver, and a behavioural deframer predicts one
// result beat per accepted byte. A monitor compares every result beat with the
// oldest prediction, field by field. Stimulus opens with directed frames and
// control bytes, then one overlong frame that fills the payload to its limit
// and runs a byte past it, then random traffic that is mostly well-formed
// frames with random payload and checksum faults, under three sender and
// receiver stall patterns.
// ----------------------------------------------------------------------------
module testbench;
  import rspd_pkg::*;

  // Cycles without any beat moving before the run is abandoned.
  localparam int StallLimit = 2000;
  // Cycles allowed after the last expected result for stray beats to show.
  localparam int DrainCycles = 10;

  typedef enum int {CkGood, CkWrong, CkBadFirst, CkBadSecond} ck_mode_t;

  typedef struct {
    logic [7:0] b;
    bit         hold;
  } link_item_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] event_res;
  logic [7:0] data_byte;
  logic [1:0] reply;

  // Bytes waiting to go onto the link, and result beats still owed.
  link_item_t link_bytes[$];
  res_t       owed_results[$];
  logic [7:0] frame_body[$];

  int send_gap_pct = 13;
  int recv_gap_pct = 50;
  int n_accepted = 0;
  int n_checked = 0;
  int n_queued = 0;
  int error_count = 0;
  int idle_cycles = 0;

  // Deframer state as the bench sees it.
  logic [1:0] frame_ph = PhIdle;
  logic [7:0] frame_sum = 8'h00;
  logic [3:0] first_nib = 4'h0;
  bit         first_ok = 1'b0;
  int         frame_len = 0;

  int n_payload = 0;
  int n_good = 0;
  int n_bad = 0;
  int n_ctrl = 0;
  int n_stray = 0;

  rsp_packet_deframer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .event_res (event_res),
    .data_byte (data_byte),
    .reply     (reply)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Lowercase hex digit check; the value is zero for anything else.
  function automatic bit hex_value(input logic [7:0] c, output logic [3:0] v);
    v = 4'h0;
    if (c >= "0" && c <= "9") begin
      v = 4'(c - 8'h30);
      return 1'b1;
    end
    if (c >= "a" && c <= "f") begin
      v = 4'(c - 8'h57);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [7:0] nib_char(input logic [3:0] n);
    return (n < 4'd10) ? 8'h30 + 8'(n) : 8'h61 + 8'(n) - 8'd10;
  endfunction

  // Any byte that is not a lowercase hex digit, often an uppercase letter.
  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    logic [3:0] v;
    if ($urandom_range(0, 1) == 0) begin
      return 8'h41 + 8'($urandom_range(0, 5));
    end
    do begin
      c = 8'($urandom_range(0, 255));
    end while (hex_value(c, v));
    return c;
  endfunction

  // Works out the result beat that one link byte causes and records it.
  task automatic deframe_byte(input logic [7:0] b);
    res_t       r;
    logic [3:0] d;
    logic [7:0] claimed;
    r = '0;
    case (frame_ph)
      PhIdle: begin
        if (b == ChAck) begin
          r.event_res = EvAck;
          n_ctrl++;
        end else if (b == ChNak) begin
          r.event_res = EvNak;
          n_ctrl++;
        end else if (b == ChBreak) begin
          r.event_res = EvBreak;
          n_ctrl++;
        end else if (b == ChStart) begin
          frame_ph = PhBody;
          frame_sum = 8'h00;
          frame_len = 0;
          first_nib = 4'h0;
          first_ok = 1'b0;
        end else begin
          r.event_res = EvStray;
          r.reply = RpNak;
          n_stray++;
        end
      end
      PhBody: begin
        if (b == ChEnd) begin
          frame_ph = PhHex1;
        end else if (frame_len >= MaxPayload) begin
          // The payload has run past its limit: the frame is cut off.
          r.event_res = EvBad;
          r.data_byte = frame_sum;
          r.reply = RpNak;
          frame_ph = PhIdle;
          n_bad++;
        end else begin
          r.event_res = EvData;
          r.data_byte = b;
          frame_sum = frame_sum + b;
          frame_len++;
          n_payload++;
        end
      end
      PhHex1: begin
        first_ok = hex_value(b, d);
        first_nib = d;
        frame_ph = PhHex2;
      end
      default: begin
        // Parsing stops at the first bad digit and keeps what it has.
        claimed = 8'h00;
        if (first_ok) begin
          claimed = {4'h0, first_nib};
          if (hex_value(b, d)) begin
            claimed = {first_nib, d};
          end
        end
        r.data_byte = frame_sum;
        if (claimed == frame_sum) begin
          r.event_res = EvGood;
          r.reply = RpAck;
          n_good++;
        end else begin
          r.event_res = EvBad;
          r.reply = RpNak;
          n_bad++;
        end
        frame_ph = PhIdle;
      end
    endcase
    owed_results.push_back(r);
  endtask

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic queue_byte(input logic [7:0] b, input bit hold);
    link_item_t it;
    it.b = b;
    it.hold = hold;
    link_bytes.push_back(it);
    n_queued++;
  endtask

  // Random payload with no closing mark, biased towards framing characters.
  task automatic fill_body(input int len);
    logic [7:0] b;
    frame_body.delete();
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 4))
          0: b = ChStart;
          1: b = ChBreak;
          2: b = ChAck;
          3: b = ChNak;
          default: b = 8'h00;
        endcase
      end
      if (b == ChEnd) begin
        b = 8'hFF;
      end
      frame_body.push_back(b);
    end
  endtask

  // Queues a whole frame around frame_body with the chosen checksum fault.
  task automatic add_frame(input ck_mode_t mode, input bit hold);
    logic [7:0] sum;
    logic [7:0] claimed;
    logic [7:0] hi;
    logic [7:0] lo;
    sum = 8'h00;
    queue_byte(ChStart, hold);
    foreach (frame_body[i]) begin
      queue_byte(frame_body[i], 1'b0);
      sum = sum + frame_body[i];
    end
    queue_byte(ChEnd, 1'b0);
    case (mode)
      CkGood: begin
        hi = nib_char(sum[7:4]);
        lo = nib_char(sum[3:0]);
      end
      CkWrong: begin
        claimed = sum ^ 8'($urandom_range(1, 255));
        hi = nib_char(claimed[7:4]);
        lo = nib_char(claimed[3:0]);
      end
      CkBadFirst: begin
        hi = non_hex_char();
        lo = 8'($urandom_range(0, 255));
      end
      default: begin
        hi = nib_char(($urandom_range(0, 1) == 0) ? sum[3:0] : sum[7:4]);
        lo = non_hex_char();
      end
    endcase
    queue_byte(hi, 1'b0);
    queue_byte(lo, 1'b0);
  endtask

  // Mostly well-formed frames, with control bytes, noise and broken frames.
  task automatic add_traffic(input int target);
    int       first;
    int       pick;
    int       k;
    ck_mode_t mode;
    first = n_queued;
    while (n_queued - first < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        fill_body(($urandom_range(0, 9) == 0) ? $urandom_range(21, 60) : $urandom_range(0, 20));
        k = $urandom_range(0, 9);
        mode = (k < 7) ? CkGood : (k == 7) ? CkWrong : (k == 8) ? CkBadFirst : CkBadSecond;
        add_frame(mode, $urandom_range(0, 49) == 0);
      end else if (pick < 80) begin
        k = $urandom_range(0, 2);
        queue_byte((k == 0) ? ChAck : (k == 1) ? ChNak : ChBreak, 1'b0);
      end else if (pick < 90) begin
        queue_byte(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        // A frame that stops short; later bytes land in its payload or checksum.
        queue_byte(ChStart, 1'b0);
        fill_body($urandom_range(0, 6));
        foreach (frame_body[i]) begin
          queue_byte(frame_body[i], 1'b0);
        end
        if ($urandom_range(0, 1) == 0) begin
          queue_byte(ChEnd, 1'b0);
          queue_byte(nib_char(4'($urandom_range(0, 15))), 1'b0);
        end
      end
    end
  endtask

  task automatic wait_drained();
    while (link_bytes.size() != 0 || in_valid || n_checked != n_accepted) begin
      @(negedge clk);
    end
  endtask

  // Link byte driver: one beat offered at a time, held until it is taken.
  always @(posedge clk) begin : drive_link
    bit busy;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid && !in_ready;
      if (in_valid && in_ready) begin
        deframe_byte(rx_byte);
        n_accepted <= n_accepted + 1;
      end
      if (!busy) begin
        if (link_bytes.size() > 0 &&
            !(link_bytes[0].hold && (in_valid || n_accepted != n_checked)) &&
            $urandom_range(0, 99) >= send_gap_pct) begin
          in_valid <= 1'b1;
          rx_byte <= link_bytes[0].b;
          void'(link_bytes.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each beat taken against the oldest prediction.
  always @(posedge clk) begin : watch_results
    res_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_checked <= n_checked + 1;
        if (owed_results.size() == 0) begin
          flag_mismatch($sformatf("result beat ev=%0d data=%02h reply=%0d with none expected",
                                  event_res, data_byte, reply));
        end else begin
          want = owed_results.pop_front();
          if (event_res !== want.event_res) begin
            flag_mismatch($sformatf("beat %0d event_res %0d, expected %0d",
                                    n_checked, event_res, want.event_res));
          end
          if (data_byte !== want.data_byte) begin
            flag_mismatch($sformatf("beat %0d data_byte %02h, expected %02h",
                                    n_checked, data_byte, want.data_byte));
          end
          if (reply !== want.reply) begin
            flag_mismatch($sformatf("beat %0d reply %0d, expected %0d",
                                    n_checked, reply, want.reply));
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_gap_pct);
    end
  end

  // Watchdog on cycles in which no beat moves on either side.
  always @(posedge clk) begin : watchdog
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("Watchdog: no beat moved for %0d cycles", StallLimit);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Stimulus sequence and end of run.
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Control bytes and strays at both ends of the byte range.
    queue_byte(ChAck, 1'b0);
    queue_byte(ChNak, 1'b0);
    queue_byte(ChBreak, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    // Empty frame, sent only once everything before it has come back.
    frame_body.delete();
    add_frame(CkGood, 1'b1);
    // Framing characters and the byte extremes inside a payload.
    frame_body = '{ChStart, ChBreak, ChAck, ChNak, 8'h00, 8'hFF};
    add_frame(CkGood, 1'b0);
    // A bad first digit counts as zero, which matches an empty payload.
    frame_body.delete();
    add_frame(CkBadFirst, 1'b0);
    // A good first digit alone, then a bad second digit.
    frame_body = '{8'h05};
    add_frame(CkBadSecond, 1'b0);
    wait_drained();

    // A payload that fills the limit exactly and then runs a byte over it.
    recv_gap_pct = 13;
    fill_body(MaxPayload + 1);
    queue_byte(ChStart, 1'b1);
    foreach (frame_body[i]) begin
      queue_byte(frame_body[i], 1'b0);
    end
    wait_drained();

    send_gap_pct = 13;
    recv_gap_pct = 50;
    add_traffic(50);
    wait_drained();

    send_gap_pct = 50;
    recv_gap_pct = 13;
    add_traffic(50);
    wait_drained();

    send_gap_pct = 0;
    recv_gap_pct = 0;
    add_traffic(50);
    wait_drained();

    repeat (DrainCycles) @(posedge clk);
    if (owed_results.size() != 0) begin
      flag_mismatch($sformatf("%0d expected result beats never arrived", owed_results.size()));
    end
    $display("Ran %0d link bytes: %0d payload bytes, %0d good and %0d rejected packets,",
             n_accepted, n_payload, n_good, n_bad);
    $display("%0d acks, naks or breaks and %0d strays, under three stall patterns.",
             n_ctrl, n_stray);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* rsp_packet_deframer.f */
design/rspd_pkg.sv
design/rspd_core.sv
design/rsp_packet_deframer.sv
verif/testbench.sv
